FILE: design/lmqsr_pkg.sv
package lmqsr_pkg;

  // Item opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration register map.
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 5;
  localparam logic [CFG_IW-1:0] CFG_ROW_BYTES = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_SCAN_RATE = 1'b1;

  // Result buffer depth and the width of its fill level.
  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_LW    = 3;

  typedef struct packed {
    logic       opcode;
    logic [8:0] write_address;
    logic [7:0] write_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic [2:0] row_select;
    logic       latch_last;
  } out_t;

  // One classified command waiting between front and back.
  typedef struct packed {
    logic       is_tick;
    logic [8:0] addr;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

FILE: design/led_matrix_quarter_scan_refresh_top.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+----------------------------------------
// in_      | input     | in_valid / in_ready  | in_data: opcode, write_address, write_byte
// out_     | output    | out_valid / out_ready| out_data: shift_byte, row_select, latch_last
// cfg_     | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// A write item is written to the frame store as it is popped. A tick item passes a set-up state and
// then issues 4*row_bytes frame store reads, one result each.
// After reset the frame store is swept to zero, one byte a cycle;
// in_ready stays low during the sweep while configuration writes are still taken.
// A two-entry command queue lets input items be taken while a tick is running, and a
// four-entry result buffer absorbs stalls on out_ready without losing reads in flight.
module led_matrix_quarter_scan_refresh_top #(
  parameter int FRAME_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lmqsr_pkg::in_t                in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lmqsr_pkg::out_t               out_data,
  input  logic                          cfg_we,
  input  logic [lmqsr_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [lmqsr_pkg::CFG_DW-1:0]  cfg_wdata
);
  import lmqsr_pkg::*;

  // Configuration registers hold the written values (the scan rate keeps its low four bits); the back end clamps them.
  logic [4:0] row_bytes_r;
  logic [3:0] scan_rate_r;

  q_head_t            q_head;
  logic               q_pop;
  logic               clearing;
  logic [OBUF_LW-1:0] obuf_level;
  logic               obuf_push;
  out_t               obuf_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= 5'd4;
      scan_rate_r <= 4'd4;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROW_BYTES) begin
        row_bytes_r <= cfg_wdata;
      end
      if (cfg_index == CFG_SCAN_RATE) begin
        scan_rate_r <= cfg_wdata[3:0];
      end
    end
  end

  // Front end: takes items, drops writes beyond the store and queues the rest.
  lmqsr_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .clearing (clearing),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // Back end: owns the frame store and the scan index, and walks the tick addresses.
  lmqsr_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_bytes  (row_bytes_r),
    .scan_rate  (scan_rate_r),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .obuf_level (obuf_level),
    .obuf_push  (obuf_push),
    .obuf_data  (obuf_data)
  );

  // Result buffer: reads are only issued while it has room for them.
  lmqsr_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (obuf_push),
    .push_data (obuf_data),
    .level     (obuf_level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/lmqsr_front.sv
module lmqsr_front #(
  parameter int FRAME_BYTES = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lmqsr_pkg::in_t    in_data,
  input  logic              clearing,
  output lmqsr_pkg::q_head_t q_head,
  input  logic              q_pop
);
  import lmqsr_pkg::*;

  cmd_t       q_mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept, keep, pop;
  cmd_t       cmd_in;

  assign in_ready = (cnt_r != 2'd2) && !clearing;
  assign accept   = in_valid && in_ready;

  // Writes that fall outside the frame store are accepted and dropped here.
  assign keep = accept &&
                ((in_data.opcode == OP_TICK) || (in_data.write_address < FRAME_BYTES));
  assign pop  = q_pop && (cnt_r != 2'd0);

  always_comb begin
    cmd_in.is_tick = (in_data.opcode == OP_TICK);
    cmd_in.addr    = in_data.write_address;
    cmd_in.data    = in_data.write_byte;
  end

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cmd   = q_mem_r[rptr_r];

  always_comb begin
    wptr_nxt = keep ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(keep) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      q_mem_r[wptr_r] <= cmd_in;
    end
  end

endmodule

FILE: design/lmqsr_back.sv
module lmqsr_back #(
  parameter int FRAME_BYTES = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [4:0]                     row_bytes,
  input  logic [3:0]                     scan_rate,
  input  lmqsr_pkg::q_head_t             q_head,
  output logic                           q_pop,
  output logic                           clearing,
  input  logic [lmqsr_pkg::OBUF_LW-1:0]  obuf_level,
  output logic                           obuf_push,
  output lmqsr_pkg::out_t                obuf_data
);
  import lmqsr_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_SETUP = 4'b0100,
    ST_RUN   = 4'b1000
  } state_t;

  function automatic logic [4:0] clamp_rb(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'd16) return 5'd16;
    return v;
  endfunction

  function automatic logic [3:0] clamp_sr(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v > 4'd8) return 4'd8;
    return v;
  endfunction

  logic [7:0] mem [FRAME_BYTES];

  state_t     state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [2:0] scan_r;
  logic [6:0] col_r;
  logic [7:0] stride_r;
  logic [8:0] stride3_r;
  logic [3:0] i_r;
  logic [1:0] g_r;
  logic [3:0] rb_m1_r;
  logic       pend_r;
  logic       pend_inr_r;
  logic       pend_last_r;
  logic [2:0] pend_row_r;
  logic [7:0] rd_data_r;

  logic [4:0] rb;
  logic [3:0] sr;
  logic [4:0] sr3;
  logic [7:0] base_w;
  logic [7:0] stride_w;
  logic [8:0] stride3_w;
  logic [8:0] gmul;
  logic [9:0] addr;
  logic       in_range;
  logic       room;
  logic       issue;
  logic       last;
  logic [3:0] scan_inc;
  logic       clr_done;
  logic       wr_en;
  logic [AW-1:0] wr_idx;
  logic [7:0] wr_data;

  assign rb        = clamp_rb(row_bytes);
  assign sr        = clamp_sr(scan_rate);
  assign sr3       = 5'(sr) + {sr, 1'b0};
  assign base_w    = 8'(rb) * 8'(scan_r);
  assign stride_w  = 8'(rb) * 8'(sr);
  assign stride3_w = 9'(rb) * 9'(sr3);

  always_comb begin
    case (g_r)
      2'd3:    gmul = stride3_r;
      2'd2:    gmul = {stride_r, 1'b0};
      2'd1:    gmul = 9'(stride_r);
      default: gmul = 9'd0;
    endcase
  end

  assign addr     = 10'(col_r) + 10'(gmul);
  assign in_range = (addr < FRAME_BYTES);
  assign room     = ((4'(obuf_level) + 4'(pend_r)) < 4'(OBUF_DEPTH));
  assign issue    = (state_r == ST_RUN) && room;
  assign last     = (g_r == 2'd0) && (i_r == rb_m1_r);
  assign scan_inc = 4'(scan_r) + 4'd1;
  assign clr_done = (clr_cnt_r == AW'(FRAME_BYTES - 1));

  assign clearing = (state_r == ST_CLEAR);
  assign q_pop    = (state_r == ST_IDLE) && q_head.valid;

  assign wr_en   = clearing || (q_pop && !q_head.cmd.is_tick);
  assign wr_idx  = clearing ? clr_cnt_r : AW'(q_head.cmd.addr);
  assign wr_data = clearing ? 8'd0 : q_head.cmd.data;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_head.valid && q_head.cmd.is_tick) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_RUN;
      ST_RUN:   if (issue && last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      scan_r    <= 3'd0;
      pend_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= issue;
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (issue && last) begin
        scan_r <= (scan_inc >= 4'(sr)) ? 3'd0 : scan_inc[2:0];
      end
    end
  end

  // Address walk: group offsets descend within a column, then the column steps.
  always_ff @(posedge clk) begin
    if (state_r == ST_SETUP) begin
      col_r     <= base_w[6:0];
      stride_r  <= stride_w;
      stride3_r <= stride3_w;
      rb_m1_r   <= 4'(rb - 5'd1);
      i_r       <= 4'd0;
      g_r       <= 2'd3;
    end else if (issue) begin
      g_r <= g_r - 2'd1;
      if (g_r == 2'd0) begin
        i_r   <= i_r + 4'd1;
        col_r <= col_r + 7'd1;
      end
    end
    if (issue) begin
      pend_inr_r  <= in_range;
      pend_last_r <= last;
      pend_row_r  <= last ? scan_r : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[AW'(addr)];
    end
  end

  assign obuf_push            = pend_r;
  assign obuf_data.shift_byte = pend_inr_r ? rd_data_r : 8'd0;
  assign obuf_data.row_select = pend_row_r;
  assign obuf_data.latch_last = pend_last_r;

endmodule

FILE: design/lmqsr_obuf.sv
module lmqsr_obuf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  lmqsr_pkg::out_t               push_data,
  output logic [lmqsr_pkg::OBUF_LW-1:0] level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lmqsr_pkg::out_t               out_data
);
  import lmqsr_pkg::*;

  localparam int PW = $clog2(OBUF_DEPTH);

  out_t            buf_r [OBUF_DEPTH];
  logic [PW-1:0]   wptr_r;
  logic [PW-1:0]   rptr_r;
  logic [OBUF_LW-1:0] cnt_r, cnt_nxt;
  logic            pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = buf_r[rptr_r];
  assign pop       = out_valid && out_ready;
  assign level     = cnt_r;
  assign cnt_nxt   = cnt_r + OBUF_LW'(push) - OBUF_LW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= push_data;
    end
  end

endmodule

FILE: design/lmqsr_props.sv
module lmqsr_props (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input lmqsr_pkg::in_t                in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input lmqsr_pkg::out_t               out_data,
  input logic                          cfg_we,
  input logic [lmqsr_pkg::CFG_IW-1:0]  cfg_index,
  input logic [lmqsr_pkg::CFG_DW-1:0]  cfg_wdata
);
  import lmqsr_pkg::*;

  logic [3:0] ticks_r;
  logic [1:0] grp_r;
  logic       tick_in;
  logic       out_fire;
  logic       latch_out;
  logic       unused_cfg;

  assign tick_in    = in_valid && in_ready && (in_data.opcode == OP_TICK);
  assign out_fire   = out_valid && out_ready;
  assign latch_out  = out_fire && out_data.latch_last;
  assign unused_cfg = cfg_we && (cfg_index == CFG_ROW_BYTES) && (cfg_wdata == '0);

  // Ticks taken whose closing item has not yet been delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= 4'd0;
      grp_r   <= 2'd0;
    end else begin
      ticks_r <= ticks_r + 4'(tick_in) - 4'(latch_out);
      if (out_fire) begin
        grp_r <= grp_r + 2'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_latch_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.latch_last |-> ticks_r != 4'd0)
    else $error("latch item without a pending tick");

  a_latch_group: assert property (@(posedge clk) disable iff (!rst_n)
    latch_out |-> grp_r == 2'd3)
    else $error("tick closed part way through a column of four groups");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready && !out_valid)
    else $error("items taken or shown before the frame store sweep");

  a_row_on_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.latch_last && !unused_cfg |-> out_data.row_select == 3'd0)
    else $error("row select set on an item other than the last");

endmodule

bind led_matrix_quarter_scan_refresh_top lmqsr_props u_props (.*);

FILE: test/tb_led_matrix_quarter_scan_refresh_top.sv
`timescale 1ns / 100ps

module tb_led_matrix_quarter_scan_refresh_top;
  import lmqsr_pkg::*;

  localparam int FRAME_BYTES = 512;
  localparam int FB_AW = $clog2(FRAME_BYTES);
  localparam int CLK_PERIOD = 10;
  // A tick can keep the back end busy after its last result
  // has been predicted, so this many quiet cycles are enough for the block to
  // be idle once nothing is outstanding.
  localparam int SETTLE_CYCLES = 80;
  // The clearing sweep after reset and the long receiver hold-off are the
  // longest stretches without any accepted item; this is several times both.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // Our own copy of the panel state: the frame store, the scan row pointer
  // and the raw register values as last written.
  logic [7:0] frame_copy [FRAME_BYTES] = '{default: 8'h00};
  logic [2:0] scan_now = 3'd0;
  logic [4:0] row_bytes_reg = 5'd4;
  logic [3:0] scan_rate_reg = 4'd4;

  // Items waiting to be offered, and the bytes the panel should shift out.
  in_t queued_items[$];
  out_t expected_bytes[$];

  // Handshake bookkeeping between the edges. item_gone is set at the rising
  // edge that accepts an item and cleared by the driver at the next falling
  // edge, so the two processes never touch it in the same time step.
  bit item_gone = 1'b0;
  bit tx_gappy = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  rx_mode_t rx_mode = RX_STEADY;
  int hold_off_left = 0;
  int rx_count = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  led_matrix_quarter_scan_refresh_top #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Registers are clamped when a tick uses them: zero counts as one, and
  // anything past the panel limits saturates.
  function automatic int unsigned eff_row_bytes();
    if (row_bytes_reg == 5'd0) return 1;
    if (row_bytes_reg > 5'd16) return 16;
    return row_bytes_reg;
  endfunction

  function automatic int unsigned eff_scan_rate();
    if (scan_rate_reg == 4'd0) return 1;
    if (scan_rate_reg > 4'd8) return 8;
    return scan_rate_reg;
  endfunction

  // Applies one accepted item to the copy of the panel state. A write only
  // updates the frame store. A tick walks the byte columns of the current
  // scan row and, within each column, the four panel groups from the bottom
  // one upwards, queueing one byte per frame store read. The final byte
  // carries the row address and the latch mark; the scan row then advances,
  // wrapping to zero once it reaches the scan rate (a pointer already past a
  // freshly lowered scan rate is still used once before it wraps).
  function automatic void scan_out_item(in_t item);
    int unsigned rb;
    int unsigned sr;
    int unsigned base;
    int unsigned stride;
    int unsigned addr;
    out_t res;
    if (item.opcode == OP_WRITE) begin
      if (item.write_address < FRAME_BYTES) frame_copy[item.write_address] = item.write_byte;
      return;
    end
    rb = eff_row_bytes();
    sr = eff_scan_rate();
    base = rb * scan_now;
    stride = rb * sr;
    for (int unsigned col = 0; col < rb; col++) begin
      for (int grp = 3; grp >= 0; grp--) begin
        addr = base + int'(grp) * stride + col;
        res.shift_byte = (addr < FRAME_BYTES) ? frame_copy[addr[FB_AW-1:0]] : 8'h00;
        res.row_select = 3'd0;
        res.latch_last = 1'b0;
        if (col == rb - 1 && grp == 0) begin
          res.row_select = scan_now;
          res.latch_last = 1'b1;
        end
        expected_bytes.push_back(res);
      end
    end
    scan_now = (scan_now + 1 >= sr) ? 3'd0 : scan_now + 3'd1;
  endfunction

  // Sender. New payload is presented on the falling edge, only once the
  // previous item has been taken. In gappy mode items go out in bursts of
  // random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_gone) begin
      item_gone = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_items.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= queued_items[0];
        if (burst_left > 0) begin
          burst_left--;
        end else if (tx_gappy) begin
          burst_left = $urandom_range(0, 11);
          gap_left = $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. A requested hold-off is counted down here, one cycle at a time;
  // otherwise ready follows the stall pattern of the current phase.
  always @(negedge clk) begin
    rx_count++;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_PERIODIC: out_ready <= (rx_count % 7) < 4;
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Monitor. Results are checked before the item accepted at the same edge is
  // predicted, so a stray result can never be matched against the bytes of a
  // tick that has only just gone in.
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: shift_byte %02h row_select %0d latch_last %0b",
                 out_data.shift_byte, out_data.row_select, out_data.latch_last);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.shift_byte !== want.shift_byte) begin
            $error("shift_byte: expected %02h, got %02h", want.shift_byte, out_data.shift_byte);
            mismatches++;
          end
          if (out_data.row_select !== want.row_select) begin
            $error("row_select: expected %0d, got %0d", want.row_select, out_data.row_select);
            mismatches++;
          end
          if (out_data.latch_last !== want.latch_last) begin
            $error("latch_last: expected %0b, got %0b", want.latch_last, out_data.latch_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        scan_out_item(in_data);
        void'(queued_items.pop_front());
        item_gone = 1'b1;
      end
    end
    // Watchdog: any accepted item on either channel counts as progress.
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic push_write(logic [8:0] addr, logic [7:0] value);
    in_t item;
    item.opcode = OP_WRITE;
    item.write_address = addr;
    item.write_byte = value;
    queued_items.push_back(item);
  endtask

  // The address and data fields of a tick carry no meaning, so they are
  // filled with noise.
  task automatic push_tick();
    in_t item;
    item.opcode = OP_TICK;
    item.write_address = 9'($urandom_range(0, FRAME_BYTES - 1));
    item.write_byte = 8'($urandom_range(0, 255));
    queued_items.push_back(item);
  endtask

  // Waits until every item has been offered and taken and every expected
  // byte has come out, then lets the back end run dry. It only returns with
  // nothing outstanding; a lost result ends the run through the watchdog.
  task automatic settle();
    while (queued_items.size() != 0 || expected_bytes.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROW_BYTES) row_bytes_reg = value;
    else scan_rate_reg = value[3:0];
  endtask

  // Registers change only with the block idle. The trailing rising edge keeps
  // later queue and mode updates away from the falling-edge processes.
  task automatic reconfigure(logic [CFG_DW-1:0] rb, logic [CFG_DW-1:0] sr);
    settle();
    set_reg(CFG_ROW_BYTES, rb);
    set_reg(CFG_SCAN_RATE, sr);
    @(posedge clk);
  endtask

  // Random traffic for one register setting. Most writes land inside the
  // area the ticks actually read, so the shifted bytes are mostly live data;
  // the rest go anywhere in the store.
  task automatic random_phase(logic [CFG_DW-1:0] rb, logic [CFG_DW-1:0] sr, int count,
                              bit gappy, rx_mode_t rx, int hold);
    int unsigned span;
    reconfigure(rb, sr);
    tx_gappy = gappy;
    rx_mode = rx;
    hold_off_left = hold;
    span = 4 * eff_row_bytes() * eff_scan_rate();
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) push_tick();
      else if ($urandom_range(0, 3) == 0) push_write(9'($urandom_range(0, FRAME_BYTES - 1)),
                                                      8'($urandom_range(0, 255)));
      else push_write(9'($urandom_range(0, span - 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Reset settings: the extreme bytes at both ends of the store, then two
    // ticks. The item waits out the clearing sweep on in_ready.
    push_write(9'd0, 8'hFF);
    push_write(9'd511, 8'h80);
    push_write(9'd1, 8'h01);
    push_tick();
    push_tick();

    // Both registers at zero behave as one: single-byte rows, no scanning.
    reconfigure(5'd0, 5'd0);
    push_tick();
    push_tick();

    // Both registers past their limits saturate. Eight ticks visit every
    // scan row, and the last one reads the top byte of the store.
    reconfigure(5'd31, 5'd15);
    push_write(9'd511, 8'hC3);
    push_write(9'd256, 8'h7E);
    repeat (8) push_tick();

    // Leave the scan pointer at row six, then drop the scan rate under it:
    // the next tick still uses row six and then wraps to row zero.
    reconfigure(5'd1, 5'd8);
    repeat (6) push_tick();
    reconfigure(5'd1, 5'd3);
    push_tick();
    push_tick();

    // Random part: the largest panel, the smallest one, a pressure phase in
    // which the receiver holds off while the sender keeps offering items,
    // and then random settings, including out-of-range register values.
    random_phase(5'd16, 5'd8, 70, 1'b1, RX_RANDOM, 0);
    random_phase(5'd1, 5'd1, 60, 1'b0, RX_STEADY, 0);
    random_phase(5'd12, 5'd8, 60, 1'b0, RX_PERIODIC, HOLD_OFF_CYCLES);
    repeat (3) begin
      random_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 55,
                   1'($urandom_range(0, 1)), rx_mode_t'($urandom_range(0, 2)), 0);
    end

    settle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/lmqsr_pkg.sv
design/lmqsr_front.sv
design/lmqsr_back.sv
design/lmqsr_obuf.sv
design/led_matrix_quarter_scan_refresh_top.sv
design/lmqsr_props.sv
test/tb_led_matrix_quarter_scan_refresh_top.sv
